### src/dtq_pkg.sv
package dtq_pkg;

  localparam int DEPTH    = 16;
  localparam int MAX_WAKE = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int WAKE_W   = $clog2(MAX_WAKE + 1);
  localparam int DELTA_W  = 16;
  localparam int OWNER_W  = 8;
  localparam int TPS_W    = 16;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ENQ  = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WOKEN = 2'd1,
    KIND_FULL  = 2'd2
  } kind_t;

  // One list node: delta to the node in front, owner, and link to the node behind.
  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [OWNER_W-1:0] owner;
    logic [IDX_W-1:0]   nxt;
  } node_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    node_t              data;
  } wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] alloc_cnt;
  } status_t;

endpackage

### src/dtq_ram.sv
module dtq_ram
  import dtq_pkg::*;
(
  input  logic             clk,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] rd_addr,
  output node_t            rd_data
);

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/dtq_tick.sv
module dtq_tick
  import dtq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [TPS_W-1:0] cfg_data,
  input  logic             tick_en,
  output logic             second
);

  logic [TPS_W-1:0] tps;
  logic [TPS_W-1:0] tick_counter;
  logic [TPS_W:0]   tick_sum;

  // The counter may sit above a freshly lowered limit; the next tick then ends the second.
  assign tick_sum = {1'b0, tick_counter} + (TPS_W + 1)'(1);
  assign second   = (tick_sum >= {1'b0, tps});

  always_ff @(posedge clk) begin
    if (rst) begin
      tps          <= TPS_W'(60);
      tick_counter <= '0;
    end else begin
      if (cfg_we) begin
        tps <= cfg_data;
      end
      if (tick_en) begin
        tick_counter <= second ? '0 : tick_sum[TPS_W-1:0];
      end
    end
  end

endmodule

### src/dtq_ctrl.sv
module dtq_ctrl
  import dtq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [DELTA_W-1:0] delay,
  input  logic [OWNER_W-1:0] owner_id,
  input  logic               second,
  output logic [IDX_W-1:0]   rd_addr,
  input  node_t              rd_data,
  output wr_t                wr,
  output logic               out_valid,
  input  logic               out_stall,
  output kind_t              kind,
  output logic [OWNER_W-1:0] woken_owner,
  output logic               last,
  output status_t            status
);

  typedef enum logic [3:0] {
    S_IDLE, S_FREE_CAP, S_WALK, S_W_SUCC, S_W_PREV, S_W_NEW,
    S_TICK_HEAD, S_POP, S_PEEK, S_EMIT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   alloc_cnt;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   free_head;
  logic [IDX_W-1:0]   new_node;
  logic [IDX_W-1:0]   prev;
  logic [IDX_W-1:0]   cur;
  logic               has_prev;
  node_t              prev_word;
  node_t              cur_word;
  logic [DELTA_W-1:0] rem;
  logic [OWNER_W-1:0] owner_r;
  logic [CNT_W-1:0]   walk_i;
  logic [WAKE_W-1:0]  n_woken;
  logic               second_r;
  kind_t              pend_kind;
  logic [OWNER_W-1:0] pend_owner;
  logic               pend_last;

  logic               accept;
  logic               out_free;
  logic               load_out;
  logic               walk_adv;
  logic               walk_end;
  logic [DELTA_W-1:0] head_delta;
  logic               dec_head;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_out = out_free && (state == S_PEEK || state == S_EMIT);
  assign status   = '{count: count, alloc_cnt: alloc_cnt};

  assign walk_adv   = (rd_data.delta <= rem);
  assign walk_end   = ((walk_i + CNT_W'(1)) == count);
  assign dec_head   = second_r && (rd_data.delta != '0);
  assign head_delta = dec_head ? rd_data.delta - DELTA_W'(1) : rd_data.delta;

  always_comb begin
    rd_addr = head;
    unique case (state)
      S_IDLE: begin
        if (in_valid && opcode == OP_ENQ && alloc_cnt == CNT_W'(DEPTH)) begin
          rd_addr = free_head;
        end
      end
      S_WALK: begin
        if (walk_adv && !walk_end) begin
          rd_addr = rd_data.nxt;
        end
      end
      S_POP:   rd_addr = cur_word.nxt;
      default: rd_addr = head;
    endcase
  end

  always_comb begin
    wr = '0;
    unique case (state)
      S_TICK_HEAD: begin
        wr.en   = dec_head;
        wr.addr = head;
        wr.data = '{delta: head_delta, owner: rd_data.owner, nxt: rd_data.nxt};
      end
      S_W_SUCC: begin
        wr.en   = 1'b1;
        wr.addr = cur;
        wr.data = '{delta: cur_word.delta - rem, owner: cur_word.owner, nxt: cur_word.nxt};
      end
      S_W_PREV: begin
        wr.en   = 1'b1;
        wr.addr = prev;
        wr.data = '{delta: prev_word.delta, owner: prev_word.owner, nxt: new_node};
      end
      S_W_NEW: begin
        wr.en   = 1'b1;
        wr.addr = new_node;
        wr.data = '{delta: rem, owner: owner_r, nxt: cur};
      end
      S_POP: begin
        // The removed head goes onto the free list.
        wr.en   = 1'b1;
        wr.addr = head;
        wr.data = '{delta: cur_word.delta, owner: cur_word.owner, nxt: free_head};
      end
      default: wr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      alloc_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_stall && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (opcode == OP_ENQ) begin
              rem      <= (delay == '0) ? DELTA_W'(1) : delay;
              owner_r  <= owner_id;
              cur      <= head;
              has_prev <= 1'b0;
              walk_i   <= '0;
              if (count == CNT_W'(DEPTH)) begin
                pend_kind  <= KIND_FULL;
                pend_owner <= '0;
                pend_last  <= 1'b1;
                state      <= S_EMIT;
              end else if (alloc_cnt == CNT_W'(DEPTH)) begin
                state <= S_FREE_CAP;
              end else begin
                new_node  <= alloc_cnt[IDX_W-1:0];
                alloc_cnt <= alloc_cnt + CNT_W'(1);
                state     <= (count == '0) ? S_W_NEW : S_WALK;
              end
            end else begin
              second_r <= second;
              n_woken  <= '0;
              if (count == '0) begin
                pend_kind  <= KIND_NONE;
                pend_owner <= '0;
                pend_last  <= 1'b1;
                state      <= S_EMIT;
              end else begin
                state <= S_TICK_HEAD;
              end
            end
          end
        end
        S_FREE_CAP: begin
          new_node  <= free_head;
          free_head <= rd_data.nxt;
          state     <= (count == '0) ? S_W_NEW : S_WALK;
        end
        S_WALK: begin
          if (walk_adv) begin
            rem       <= rem - rd_data.delta;
            prev      <= cur;
            prev_word <= rd_data;
            has_prev  <= 1'b1;
            cur       <= rd_data.nxt;
            walk_i    <= walk_i + CNT_W'(1);
            if (walk_end) begin
              state <= S_W_PREV;
            end
          end else begin
            cur_word <= rd_data;
            state    <= S_W_SUCC;
          end
        end
        S_W_SUCC: begin
          state <= has_prev ? S_W_PREV : S_W_NEW;
        end
        S_W_PREV: begin
          state <= S_W_NEW;
        end
        S_W_NEW: begin
          count <= count + CNT_W'(1);
          if (!has_prev) begin
            head <= new_node;
          end
          pend_kind  <= KIND_NONE;
          pend_owner <= '0;
          pend_last  <= 1'b1;
          state      <= S_EMIT;
        end
        S_TICK_HEAD: begin
          if (head_delta != '0) begin
            pend_kind  <= KIND_NONE;
            pend_owner <= '0;
            pend_last  <= 1'b1;
            state      <= S_EMIT;
          end else begin
            cur_word <= rd_data;
            state    <= S_POP;
          end
        end
        S_POP: begin
          count      <= count - CNT_W'(1);
          n_woken    <= n_woken + WAKE_W'(1);
          free_head  <= head;
          head       <= cur_word.nxt;
          pend_kind  <= KIND_WOKEN;
          pend_owner <= cur_word.owner;
          if (count == CNT_W'(1) || n_woken == WAKE_W'(MAX_WAKE - 1)) begin
            pend_last <= 1'b1;
            state     <= S_EMIT;
          end else begin
            state <= S_PEEK;
          end
        end
        S_PEEK: begin
          // The new head is read again every cycle, so its word stays valid while stalled.
          if (out_free) begin
            out_valid   <= 1'b1;
            kind        <= KIND_WOKEN;
            woken_owner <= pend_owner;
            last        <= (rd_data.delta != '0);
            if (rd_data.delta == '0) begin
              cur_word <= rd_data;
              state    <= S_POP;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            kind        <= pend_kind;
            woken_owner <= pend_owner;
            last        <= pend_last;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/delta_timer_queue_top.sv
// Delta-list sleep queue.
//
// Input channel (in_valid / in_stall): each word is either a raw timer tick
// (opcode 0) or an enqueue of owner_id with a delay in queue seconds (opcode 1).
// A delay of zero counts as one second. Output channel (out_valid / out_stall)
// carries result words: kind, woken_owner and last, where last marks the final
// word caused by one input word. The configuration channel (cfg_valid /
// cfg_ready) writes ticks_per_second and should only be used while idle.
//
// The list lives in one memory with a registered read as a linked list with a
// free list; every list step costs one memory read. An enqueue reads the entries
// it walks past, with one more read when its node comes from the free list, then
// writes the successor and the predecessor where they exist and the new node. A
// tick decrements the head delta when a second ends and pops each entry whose
// delta is zero, waking at most MAX_WAKE owners, one result word each. One word is
// worked on at a time; the next input word is taken the cycle after its last
// result word has been loaded into the output register.
//
// Reset empties the queue, clears the tick counter and sets ticks_per_second
// to 60. When out_stall is high the result word holds and the next one waits.
module delta_timer_queue_top
  import dtq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [DELTA_W-1:0] delay,
  input  logic [OWNER_W-1:0] owner_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         kind,
  output logic [OWNER_W-1:0] woken_owner,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TPS_W-1:0]   ticks_per_second
);

  logic             tick_en;
  logic             second;
  logic [IDX_W-1:0] rd_addr;
  node_t            rd_data;
  wr_t              wr;
  kind_t            kind_e;
  status_t          status;

  assign cfg_ready = 1'b1;
  assign tick_en   = in_valid && !in_stall && (opcode == OP_TICK);
  assign kind      = kind_e;

  dtq_tick u_tick (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (ticks_per_second),
    .tick_en  (tick_en),
    .second   (second)
  );

  dtq_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dtq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .delay       (delay),
    .owner_id    (owner_id),
    .second      (second),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr          (wr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind_e),
    .woken_owner (woken_owner),
    .last        (last),
    .status      (status)
  );

  // Once a word is taken, the sequencer must be busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous word still in work");

  // A full-store rejection is always the only result of its word.
  a_full_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind_e == KIND_FULL) |-> last)
    else $error("rejection not marked last");

  // The queue never holds more entries than nodes handed out, nor hands out more than DEPTH.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (status.count <= status.alloc_cnt) && (status.alloc_cnt <= CNT_W'(DEPTH)))
    else $error("entry count out of range");

  // Only woken results carry an owner.
  a_owner_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind_e != KIND_WOKEN) |-> (woken_owner == '0))
    else $error("owner set on non-wake result");

endmodule
